FILE: rtl/core/complex_number_alu_macros.svh
// Assertion macros for the complex number ALU.
// Used by files that include it by name; expects clk and arst_n in scope.
`ifndef COMPLEX_NUMBER_ALU_MACROS_SVH
`define COMPLEX_NUMBER_ALU_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CNA_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
`define CNA_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define CNA_ASSERT(lbl, cond, msg)
`define CNA_IMPLY(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/core/cna_pkg.sv
// Shared types, widths and helpers for the complex number ALU.
// No dependencies; imported by every module of the block.
package cna_pkg;

	localparam int DATA_WIDTH = 16;
	localparam int FRAC_BITS  = 8;

	localparam int PW   = 2 * DATA_WIDTH;
	localparam int SW   = PW + 1;
	localparam int MW   = PW;
	localparam int DENW = PW;
	localparam int QW   = DATA_WIDTH;
	localparam int NW   = MW + FRAC_BITS;
	localparam int CW   = (NW > DENW + QW) ? NW : DENW + QW;

	localparam int QDEPTH     = 8;
	localparam int QPTRW      = $clog2(QDEPTH);
	localparam int QLVLW      = $clog2(QDEPTH + 1);
	localparam int BUSY_LEVEL = QDEPTH - 4;

	typedef enum logic [1:0] {OP_ADD, OP_SUB, OP_MUL, OP_DIV} op_t;
	typedef enum logic [1:0] {CLS_PASS, CLS_SHIFT, CLS_DIV, CLS_ZERO} cls_t;
	typedef enum logic [1:0] {ST_OK, ST_SAT, ST_DZ} status_t;

	typedef struct packed {
		cls_t                  cls;
		logic signed [SW-1:0]  re;
		logic signed [SW-1:0]  im;
		logic [DENW-1:0]       den;
	} q_word_t;

	typedef struct packed {
		logic    valid;
		q_word_t word;
	} q_push_t;

	typedef struct packed {
		logic                         sat;
		logic signed [DATA_WIDTH-1:0] val;
	} sat_t;

	localparam logic [MW-1:0] LIM = MW'(1) << (DATA_WIDTH - 1);
	localparam logic signed [DATA_WIDTH-1:0] DMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
	localparam logic signed [DATA_WIDTH-1:0] DMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};

	function automatic sat_t saturate(input logic neg, input logic [MW-1:0] mag,
			input logic big);
		sat_t r;
		logic [MW-1:0] n;
		n = ~mag + MW'(1);
		if (big) begin
			r.sat = 1'b1;
			r.val = neg ? DMIN : DMAX;
		end else if (neg) begin
			r.sat = (mag > LIM);
			r.val = r.sat ? DMIN : n[DATA_WIDTH-1:0];
		end else begin
			r.sat = (mag > LIM - MW'(1));
			r.val = r.sat ? DMAX : mag[DATA_WIDTH-1:0];
		end
		return r;
	endfunction

endpackage

FILE: rtl/core/complex_number_alu.sv
// Top level of the complex number ALU: front end, queue, back end.
// Depends on cna_pkg, cna_front, cna_queue and cna_back.
//
//   channel   handshake        payload
//   request   start / busy     req_type, a_real, a_imag, b_real, b_imag
//   result    strobe           res_real, res_imag, status
//
// One request per cycle while busy is low; the divider in the back end
// produces one quotient bit per stage.
// Every operation takes the same path, so results leave in request order.
// Reset clears all valid flags and the queue; no clearing pass is needed.
// busy rises only if the queue holds more than BUSY_LEVEL words; the back end never stalls.
module complex_number_alu (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic [1:0]                            req_type,
	input  logic signed [cna_pkg::DATA_WIDTH-1:0] a_real,
	input  logic signed [cna_pkg::DATA_WIDTH-1:0] a_imag,
	input  logic signed [cna_pkg::DATA_WIDTH-1:0] b_real,
	input  logic signed [cna_pkg::DATA_WIDTH-1:0] b_imag,
	output logic                                  strobe,
	output logic signed [cna_pkg::DATA_WIDTH-1:0] res_real,
	output logic signed [cna_pkg::DATA_WIDTH-1:0] res_imag,
	output logic [1:0]                            status
);
	import cna_pkg::*;

	q_push_t          push;
	q_word_t          head;
	logic             pop;
	logic [QLVLW-1:0] level;

	assign busy = (level > QLVLW'(BUSY_LEVEL));

	cna_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (start && !busy),
		.req_type (req_type),
		.a_real   (a_real),
		.a_imag   (a_imag),
		.b_real   (b_real),
		.b_imag   (b_imag),
		.push     (push)
	);

	cna_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.level  (level)
	);

	cna_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop      (pop),
		.head     (head),
		.strobe   (strobe),
		.res_real (res_real),
		.res_imag (res_imag),
		.status   (status)
	);

endmodule

FILE: rtl/core/cna_front.sv
// Front end: takes requests, forms products and sums, classifies the operation.
// Depends on cna_pkg; feeds cna_queue.
module cna_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                take,
	input  logic [1:0]                          req_type,
	input  logic signed [cna_pkg::DATA_WIDTH-1:0] a_real,
	input  logic signed [cna_pkg::DATA_WIDTH-1:0] a_imag,
	input  logic signed [cna_pkg::DATA_WIDTH-1:0] b_real,
	input  logic signed [cna_pkg::DATA_WIDTH-1:0] b_imag,
	output cna_pkg::q_push_t                    push
);
	import cna_pkg::*;

	logic                         vld_s1, vld_s2, vld_s3;
	op_t                          op_s1;
	logic signed [DATA_WIDTH-1:0] ar_s1, ai_s1, br_s1, bi_s1;
	cls_t                         cls_s1, cls_s2;
	logic signed [PW-1:0]         p_rr_s2, p_ii_s2, p_ri_s2, p_ir_s2, sq_r_s2, sq_i_s2;
	logic signed [SW-1:0]         lin_re_s1, lin_im_s1, lin_re_s2, lin_im_s2;
	q_word_t                      word_s2, word_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= take;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			op_s1 <= op_t'(req_type);
			ar_s1 <= a_real;
			ai_s1 <= a_imag;
			br_s1 <= b_real;
			bi_s1 <= b_imag;
		end
	end

	always_comb begin
		lin_re_s1 = SW'(ar_s1) + SW'(br_s1);
		lin_im_s1 = SW'(ai_s1) + SW'(bi_s1);
		unique case (op_s1) inside
			OP_ADD: cls_s1 = CLS_PASS;
			OP_SUB: begin
				cls_s1    = CLS_PASS;
				lin_re_s1 = SW'(ar_s1) - SW'(br_s1);
				lin_im_s1 = SW'(ai_s1) - SW'(bi_s1);
			end
			OP_MUL: cls_s1 = CLS_SHIFT;
			OP_DIV: cls_s1 = (br_s1 == '0 && bi_s1 == '0) ? CLS_ZERO : CLS_DIV;
			default: cls_s1 = CLS_PASS;
		endcase
	end

	always_ff @(posedge clk) begin
		cls_s2    <= cls_s1;
		lin_re_s2 <= lin_re_s1;
		lin_im_s2 <= lin_im_s1;
		p_rr_s2   <= ar_s1 * br_s1;
		p_ii_s2   <= ai_s1 * bi_s1;
		p_ri_s2   <= ar_s1 * bi_s1;
		p_ir_s2   <= ai_s1 * br_s1;
		sq_r_s2   <= br_s1 * br_s1;
		sq_i_s2   <= bi_s1 * bi_s1;
	end

	always_comb begin
		word_s2.cls = cls_s2;
		word_s2.den = DENW'($unsigned(sq_r_s2)) + DENW'($unsigned(sq_i_s2));
		case (cls_s2)
			CLS_PASS: begin
				word_s2.re = lin_re_s2;
				word_s2.im = lin_im_s2;
			end
			CLS_SHIFT: begin
				word_s2.re = SW'(p_rr_s2) - SW'(p_ii_s2);
				word_s2.im = SW'(p_ri_s2) + SW'(p_ir_s2);
			end
			CLS_DIV: begin
				word_s2.re = SW'(p_rr_s2) + SW'(p_ii_s2);
				word_s2.im = SW'(p_ir_s2) - SW'(p_ri_s2);
			end
			default: begin
				word_s2.re = '0;
				word_s2.im = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		word_s3 <= word_s2;
	end

	assign push.valid = vld_s3;
	assign push.word  = word_s3;

endmodule

FILE: rtl/core/cna_queue.sv
// Short queue between front and back end of the complex number ALU.
// Depends on cna_pkg and complex_number_alu_macros.svh.
`include "complex_number_alu_macros.svh"
module cna_queue (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cna_pkg::q_push_t          push,
	output logic                      pop,
	output cna_pkg::q_word_t          head,
	output logic [cna_pkg::QLVLW-1:0] level
);
	import cna_pkg::*;

	q_word_t          mem_q [QDEPTH];
	logic [QPTRW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QLVLW-1:0] level_q;

	assign pop   = (level_q != '0);
	assign head  = mem_q[rd_ptr_q];
	assign level = level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push.valid) wr_ptr_q <= wr_ptr_q + QPTRW'(1);
			if (pop) rd_ptr_q <= rd_ptr_q + QPTRW'(1);
			if (push.valid && !pop) level_q <= level_q + QLVLW'(1);
			else if (!push.valid && pop) level_q <= level_q - QLVLW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid) mem_q[wr_ptr_q] <= push.word;
	end

	`CNA_IMPLY(a_no_overflow, push.valid, level_q < QLVLW'(QDEPTH), "queue overflow")
	`CNA_IMPLY(a_empty_ptrs, level_q == '0, rd_ptr_q == wr_ptr_q, "empty queue, pointers differ")
	`CNA_ASSERT(a_level_range, level_q <= QLVLW'(QDEPTH), "queue level out of range")

endmodule

FILE: rtl/core/cna_back.sv
// Back end: magnitude split, pipelined restoring divider, shift and saturation.
// Depends on cna_pkg and complex_number_alu_macros.svh; fed by cna_queue.
`include "complex_number_alu_macros.svh"
module cna_back (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  pop,
	input  cna_pkg::q_word_t                      head,
	output logic                                  strobe,
	output logic signed [cna_pkg::DATA_WIDTH-1:0] res_real,
	output logic signed [cna_pkg::DATA_WIDTH-1:0] res_imag,
	output logic [1:0]                            status
);
	import cna_pkg::*;

	typedef struct packed {
		cls_t            cls;
		logic            neg_re;
		logic            neg_im;
		logic            ovf_re;
		logic            ovf_im;
		logic [MW-1:0]   fix_re;
		logic [MW-1:0]   fix_im;
		logic [DENW-1:0] den;
	} meta_t;

	logic            vld_s1;
	cls_t            cls_s1;
	logic            neg_re_s1, neg_im_s1;
	logic [MW-1:0]   mag_re_s1, mag_im_s1;
	logic [DENW-1:0] den_s1;

	logic [QW:0]   vld_q;
	meta_t         meta_q [QW+1];
	logic [CW-1:0] r_re_q [QW+1];
	logic [CW-1:0] r_im_q [QW+1];
	logic [QW-1:0] q_re_q [QW+1];
	logic [QW-1:0] q_im_q [QW+1];

	logic [CW-1:0] n_re, n_im, lim_c;
	meta_t         meta_in;
	meta_t         meta_out;
	logic          big_re, big_im;
	logic [MW-1:0] sel_re, sel_im;
	sat_t          sr, si;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_q  <= '0;
			strobe <= 1'b0;
		end else begin
			vld_s1 <= pop;
			vld_q  <= {vld_q[QW-1:0], vld_s1};
			strobe <= vld_q[QW];
		end
	end

	always_ff @(posedge clk) begin
		cls_s1    <= head.cls;
		neg_re_s1 <= head.re < 0;
		neg_im_s1 <= head.im < 0;
		mag_re_s1 <= MW'((head.re < 0) ? -head.re : head.re);
		mag_im_s1 <= MW'((head.im < 0) ? -head.im : head.im);
		den_s1    <= head.den;
	end

	always_comb begin
		n_re           = CW'(mag_re_s1) << FRAC_BITS;
		n_im           = CW'(mag_im_s1) << FRAC_BITS;
		lim_c          = CW'(den_s1) << QW;
		meta_in.cls    = cls_s1;
		meta_in.neg_re = neg_re_s1;
		meta_in.neg_im = neg_im_s1;
		meta_in.ovf_re = (n_re >= lim_c);
		meta_in.ovf_im = (n_im >= lim_c);
		meta_in.den    = den_s1;
		if (cls_s1 == CLS_SHIFT) begin
			meta_in.fix_re = mag_re_s1 >> FRAC_BITS;
			meta_in.fix_im = mag_im_s1 >> FRAC_BITS;
		end else begin
			meta_in.fix_re = mag_re_s1;
			meta_in.fix_im = mag_im_s1;
		end
	end

	always_ff @(posedge clk) begin
		meta_q[0] <= meta_in;
		r_re_q[0] <= n_re;
		r_im_q[0] <= n_im;
		q_re_q[0] <= '0;
		q_im_q[0] <= '0;
	end

	for (genvar k = 0; k < QW; k++) begin : g_div
		logic [CW-1:0] trial;
		logic          ge_re, ge_im;
		assign trial = CW'(meta_q[k].den) << (QW - 1 - k);
		assign ge_re = (r_re_q[k] >= trial);
		assign ge_im = (r_im_q[k] >= trial);
		always_ff @(posedge clk) begin
			meta_q[k+1] <= meta_q[k];
			r_re_q[k+1] <= ge_re ? r_re_q[k] - trial : r_re_q[k];
			r_im_q[k+1] <= ge_im ? r_im_q[k] - trial : r_im_q[k];
			q_re_q[k+1] <= {q_re_q[k][QW-2:0], ge_re};
			q_im_q[k+1] <= {q_im_q[k][QW-2:0], ge_im};
		end
	end

	always_comb begin
		meta_out = meta_q[QW];
		big_re   = (meta_out.cls == CLS_DIV) && meta_out.ovf_re;
		big_im   = (meta_out.cls == CLS_DIV) && meta_out.ovf_im;
		sel_re   = (meta_out.cls == CLS_DIV) ? MW'(q_re_q[QW]) : meta_out.fix_re;
		sel_im   = (meta_out.cls == CLS_DIV) ? MW'(q_im_q[QW]) : meta_out.fix_im;
		sr       = saturate(meta_out.neg_re, sel_re, big_re);
		si       = saturate(meta_out.neg_im, sel_im, big_im);
	end

	always_ff @(posedge clk) begin
		if (meta_out.cls == CLS_ZERO) begin
			res_real <= '0;
			res_imag <= '0;
			status   <= ST_DZ;
		end else begin
			res_real <= sr.val;
			res_imag <= si.val;
			status   <= (sr.sat || si.sat) ? ST_SAT : ST_OK;
		end
	end

	`CNA_IMPLY(a_dz_zero, strobe && status == ST_DZ, res_real == '0 && res_imag == '0,
		"divide by zero with nonzero result")

endmodule

FILE: test/complex_number_alu_test.sv
// Self-checking testbench for complex_number_alu: add, subtract, multiply, divide.
// Depends on cna_pkg and the complex_number_alu RTL; computes expected words itself.
`timescale 1ns / 1ps

module complex_number_alu_test;
	import cna_pkg::*;

	localparam int DW = DATA_WIDTH;
	localparam int FB = FRAC_BITS;
	localparam int WATCHDOG = 20000;

	typedef struct {
		op_t            op;
		logic [DW-1:0]  ar, ai, br, bi;
	} alu_req_t;

	typedef struct {
		logic [DW-1:0] re, im;
		status_t       st;
	} alu_res_t;

	logic clk, arst_n, start, busy, strobe;
	logic [1:0] req_type;
	logic signed [DW-1:0] a_real, a_imag, b_real, b_imag, res_real, res_imag;
	logic [1:0] status;

	alu_req_t pending_reqs[$];
	alu_res_t expected_res[$];
	int errors = 0, sent = 0, checked = 0, idle_cycles = 0, gap = 0;
	int op_count[4];
	bit drain_hold = 0, stim_done = 0;

	complex_number_alu DUT (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic logic [DW-1:0] clamp(input longint v, inout bit sat);
		longint lo, hi;
		lo = -(longint'(1) << (DW - 1));
		hi = (longint'(1) << (DW - 1)) - 1;
		if (v > hi) begin
			sat = 1;
			return DW'(hi);
		end
		if (v < lo) begin
			sat = 1;
			return DW'(lo);
		end
		return DW'(v);
	endfunction

	// Truncate toward zero for shift and divide.
	function automatic longint tdiv(input longint n, input longint d);
		longint q;
		q = (n < 0 ? -n : n) / (d < 0 ? -d : d);
		return ((n < 0) != (d < 0)) ? -q : q;
	endfunction

	function automatic alu_res_t compute_complex(input alu_req_t r);
		alu_res_t o;
		longint ar, ai, br, bi, re, im, den;
		bit sat;
		ar = longint'($signed(r.ar));
		ai = longint'($signed(r.ai));
		br = longint'($signed(r.br));
		bi = longint'($signed(r.bi));
		sat = 0;
		case (r.op)
			OP_ADD: begin
				re = ar + br;
				im = ai + bi;
			end
			OP_SUB: begin
				re = ar - br;
				im = ai - bi;
			end
			OP_MUL: begin
				re = tdiv(ar * br - ai * bi, longint'(1) << FB);
				im = tdiv(ar * bi + ai * br, longint'(1) << FB);
			end
			default: begin
				if (br == 0 && bi == 0) begin
					o.re = '0;
					o.im = '0;
					o.st = ST_DZ;
					return o;
				end
				den = br * br + bi * bi;
				re = tdiv((ar * br + ai * bi) * (longint'(1) << FB), den);
				im = tdiv((ai * br - ar * bi) * (longint'(1) << FB), den);
			end
		endcase
		o.re = clamp(re, sat);
		o.im = clamp(im, sat);
		o.st = sat ? ST_SAT : ST_OK;
		return o;
	endfunction

	task automatic report(input string what, input logic [DW-1:0] got, input logic [DW-1:0] exp);
		errors++;
		$display("mismatch word %0d %s: got %h expected %h", checked, what, got, exp);
	endtask

	function automatic logic [DW-1:0] rnd_val(input int kind);
		case (kind)
			0: return DW'($urandom);
			1: return DW'($urandom_range(0, 1023)) - DW'(512);
			2: return $urandom_range(0, 1) ? DMAX : DMIN;
			default: return DW'($urandom_range(0, 7)) - DW'(4);
		endcase
	endfunction

	function automatic alu_req_t make_req(input op_t op, input int ka, input int kb);
		alu_req_t r;
		r.op = op;
		r.ar = rnd_val(ka);
		r.ai = rnd_val(ka);
		r.br = rnd_val(kb);
		r.bi = rnd_val(kb);
		return r;
	endfunction

	initial begin
		alu_req_t r;
		logic [DW-1:0] ext[4];
		ext = '{DMIN, DMAX, '0, DW'(1) << FB};
		for (int o = 0; o < 4; o++) begin
			r.op = op_t'(o);
			r.ar = DMAX; r.ai = DMIN; r.br = DMAX; r.bi = DMIN;
			pending_reqs.push_back(r);
			r.ar = DMIN; r.ai = DMIN; r.br = DMIN; r.bi = DMIN;
			pending_reqs.push_back(r);
			r.ar = ext[o]; r.ai = ext[3 - o]; r.br = '0; r.bi = '0;
			pending_reqs.push_back(r);
			r.ar = '1; r.ai = DW'(1); r.br = DW'(1) << FB; r.bi = '1;
			pending_reqs.push_back(r);
		end
		r.op = OP_DIV; r.ar = DMAX; r.ai = DMAX; r.br = DW'(1); r.bi = '0;
		pending_reqs.push_back(r);
		r.ar = DW'(1); r.ai = '1; r.br = DMAX; r.bi = DMAX;
		pending_reqs.push_back(r);
		for (int i = 0; i < 1350; i++)
			pending_reqs.push_back(make_req(op_t'($urandom_range(0, 3)),
				$urandom_range(0, 3), $urandom_range(0, 3)));
	end

	// Driver: hold start until accepted, random gaps between words.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 0;
			req_type <= '0;
			a_real <= '0; a_imag <= '0; b_real <= '0; b_imag <= '0;
			gap <= 0;
		end else begin
			if (start && !busy) begin
				expected_res.push_back(compute_complex(pending_reqs.pop_front()));
				op_count[req_type]++;
				sent++;
				gap <= $urandom_range(0, 1) ? 0 : $urandom_range(0, 15);
				if (sent == 700)
					drain_hold <= 1;
			end
			if (start && !busy || !start) begin
				if (drain_hold && expected_res.size() == 0 && !(start && !busy))
					drain_hold <= 0;
				if (pending_reqs.size() > 0 && !drain_hold
						&& (gap == 0 || (start && !busy && gap == 0))
						&& !(start && !busy && sent == 699)) begin
					r_drive(pending_reqs[0]);
				end else begin
					start <= 0;
					if (gap > 0 && !(start && !busy))
						gap <= gap - 1;
				end
			end
		end
	end

	task automatic r_drive(input alu_req_t r);
		start <= 1;
		req_type <= r.op;
		a_real <= r.ar; a_imag <= r.ai; b_real <= r.br; b_imag <= r.bi;
	endtask

	// Monitor: compare every strobed word against the oldest prediction.
	always @(posedge clk) begin
		alu_res_t e;
		if (arst_n) begin
			if ((start && !busy) || strobe)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (strobe) begin
				if (expected_res.size() == 0) begin
					errors++;
					$display("unexpected result word %h %h %0d", res_real, res_imag, status);
				end else begin
					e = expected_res.pop_front();
					if (res_real !== e.re) report("res_real", res_real, e.re);
					if (res_imag !== e.im) report("res_imag", res_imag, e.im);
					if (status !== e.st) report("status", DW'(status), DW'(e.st));
				end
				checked++;
			end
		end
	end

	initial begin
		arst_n = 0;
		start = 0;
		req_type = '0;
		a_real = '0; a_imag = '0; b_real = '0; b_imag = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		fork
			begin
				wait (pending_reqs.size() == 0 && expected_res.size() == 0);
				repeat (DW + 20) @(posedge clk);
			end
			wait (idle_cycles >= WATCHDOG);
		join_any
		if (idle_cycles >= WATCHDOG || expected_res.size() != 0) begin
			$display("timeout with %0d words outstanding", expected_res.size());
			$display("complex_number_alu verification failed");
			$finish;
		end else begin
			$display("sent %0d requests, checked %0d results, errors %0d", sent, checked, errors);
			$display("ops add %0d sub %0d mul %0d div %0d", op_count[0], op_count[1],
				op_count[2], op_count[3]);
			if (errors == 0)
				$display("complex_number_alu verification clean");
			else
				$display("complex_number_alu verification failed");
			$finish;
		end
	end

endmodule
